// ===== rtl/hsvbl_pkg.sv =====
// Shared types, constants and microcode ROM of the HSV breathing light.
// No dependencies; the sequencer, divider, datapath, top level and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package hsvbl_pkg;

    localparam int unsigned PcW  = 5;
    localparam int unsigned DivW = 22;
    localparam int unsigned DenW = 14;
    localparam int unsigned CntW = 5;
    localparam int unsigned RecW = 23;
    localparam int unsigned RecSh = 36;

    localparam logic [DenW-1:0] ScaleQ  = 14'd15300;
    localparam logic [RecW-1:0] RecipQ  = 23'd4491470;
    localparam logic [7:0]      Full    = 8'd255;
    localparam logic [7:0]      LowThr  = 8'd5;
    localparam logic [8:0]      Deg360  = 9'd360;
    localparam logic [5:0]      SecDeg  = 6'd60;
    localparam logic [CntW-1:0] SCnt    = 5'd16;
    localparam logic [CntW-1:0] HCnt    = 5'd17;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2,
        REG_RATE  = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_S_START,
        OP_S_STORE,
        OP_H_START,
        OP_H_STORE,
        OP_RAMP,
        OP_MUL_SF,
        OP_MUL_SG,
        OP_MUL_P,
        OP_MUL_Q,
        OP_MUL_T,
        OP_EMIT,
        OP_GRAY
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_BUSY,
        C_OUT_BUSY,
        C_GRAY
    } t_cond;

    typedef struct packed {
        t_op            op;
        t_cond          wait_c;
        t_cond          jmp_c;
        logic [PcW-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_busy;
        logic gray;
    } t_sts;

    localparam logic [PcW-1:0] PC_IDLE   = 5'd0;
    localparam logic [PcW-1:0] PC_CHECK  = 5'd1;
    localparam logic [PcW-1:0] PC_S_GO   = 5'd2;
    localparam logic [PcW-1:0] PC_S_WAIT = 5'd3;
    localparam logic [PcW-1:0] PC_S_PUT  = 5'd4;
    localparam logic [PcW-1:0] PC_H_GO   = 5'd5;
    localparam logic [PcW-1:0] PC_H_WAIT = 5'd6;
    localparam logic [PcW-1:0] PC_H_PUT  = 5'd7;
    localparam logic [PcW-1:0] PC_RAMP   = 5'd8;
    localparam logic [PcW-1:0] PC_M_SF   = 5'd9;
    localparam logic [PcW-1:0] PC_M_SG   = 5'd10;
    localparam logic [PcW-1:0] PC_M_P    = 5'd11;
    localparam logic [PcW-1:0] PC_M_Q    = 5'd12;
    localparam logic [PcW-1:0] PC_M_T    = 5'd13;
    localparam logic [PcW-1:0] PC_EMIT   = 5'd14;
    localparam logic [PcW-1:0] PC_GRAY   = 5'd15;

    function automatic t_uword uw(input t_op op, input t_cond wc, input t_cond jc,
                                  input logic [PcW-1:0] tgt);
        t_uword w;
        w.op     = op;
        w.wait_c = wc;
        w.jmp_c  = jc;
        w.target = tgt;
        return w;
    endfunction

    // Program: hold on wait_c, else jump on jmp_c, else fall through.
    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = uw(OP_IDLE,    C_NO_INPUT, C_NEVER,  PC_IDLE);
            PC_CHECK:  w = uw(OP_NOP,     C_NEVER,    C_GRAY,   PC_GRAY);
            PC_S_GO:   w = uw(OP_S_START, C_NEVER,    C_NEVER,  PC_IDLE);
            PC_S_WAIT: w = uw(OP_NOP,     C_DIV_BUSY, C_NEVER,  PC_IDLE);
            PC_S_PUT:  w = uw(OP_S_STORE, C_NEVER,    C_NEVER,  PC_IDLE);
            PC_H_GO:   w = uw(OP_H_START, C_NEVER,    C_NEVER,  PC_IDLE);
            PC_H_WAIT: w = uw(OP_NOP,     C_DIV_BUSY, C_NEVER,  PC_IDLE);
            PC_H_PUT:  w = uw(OP_H_STORE, C_NEVER,    C_NEVER,  PC_IDLE);
            PC_RAMP:   w = uw(OP_RAMP,    C_NEVER,    C_NEVER,  PC_IDLE);
            PC_M_SF:   w = uw(OP_MUL_SF,  C_NEVER,    C_NEVER,  PC_IDLE);
            PC_M_SG:   w = uw(OP_MUL_SG,  C_NEVER,    C_NEVER,  PC_IDLE);
            PC_M_P:    w = uw(OP_MUL_P,   C_NEVER,    C_NEVER,  PC_IDLE);
            PC_M_Q:    w = uw(OP_MUL_Q,   C_NEVER,    C_NEVER,  PC_IDLE);
            PC_M_T:    w = uw(OP_MUL_T,   C_NEVER,    C_NEVER,  PC_IDLE);
            PC_EMIT:   w = uw(OP_EMIT,    C_OUT_BUSY, C_ALWAYS, PC_IDLE);
            PC_GRAY:   w = uw(OP_GRAY,    C_NEVER,    C_ALWAYS, PC_RAMP);
            default:   w = uw(OP_NOP,     C_NEVER,    C_ALWAYS, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsvbl_if.sv =====
// Channel interfaces of the HSV breathing light: tick input, color output,
// register write port. Stand-alone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface hsvbl_in_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

interface hsvbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic       falling;

    modport source (output valid, output red, output green, output blue,
                    output level, output falling, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input level, input falling, output ready);
endinterface

interface hsvbl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsvbl_seq.sv =====
// Microcode sequencer: step counter, control ROM from hsvbl_pkg, wait and
// jump condition evaluation. Depends on hsvbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvbl_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsvbl_pkg::t_sts   i_sts,
    output hsvbl_pkg::t_ctl   o_ctl
);
    import hsvbl_pkg::*;

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    t_uword         w_word;
    logic           w_hold;
    logic           w_jump;

    function automatic logic cond_true(input t_cond c, input t_sts s);
        logic res;
        unique case (c)
            C_NEVER:    res = 1'b0;
            C_ALWAYS:   res = 1'b1;
            C_NO_INPUT: res = !s.in_valid;
            C_DIV_BUSY: res = s.div_busy;
            C_OUT_BUSY: res = s.out_busy;
            C_GRAY:     res = s.gray;
            default:    res = 1'b0;
        endcase
        return res;
    endfunction

    always_comb begin
        w_word = ucode(r_pc);
        w_hold = cond_true(w_word.wait_c, i_sts);
        w_jump = cond_true(w_word.jmp_c, i_sts);
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op       = w_word.op;
    assign o_ctl.in_ready = (r_pc == PC_IDLE);

endmodule

`default_nettype wire

// ===== rtl/hsvbl_div.sv =====
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
// Depends on hsvbl_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module hsvbl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hsvbl_pkg::DivW-1:0]  i_num,
    input  logic [hsvbl_pkg::DenW-1:0]  i_den,
    input  logic [hsvbl_pkg::CntW-1:0]  i_cnt,
    output logic                        o_busy,
    output logic [hsvbl_pkg::DivW-1:0]  o_quo
);
    import hsvbl_pkg::*;

    logic [DivW-1:0] r_num;
    logic [DivW-1:0] r_quo;
    logic [DenW-1:0] r_rem;
    logic [DenW-1:0] r_den;
    logic [CntW-1:0] r_cnt;
    logic [DenW:0]   w_trial;
    logic [DenW:0]   w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_num[DivW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_cnt;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[DivW-2:0], 1'b0};
            r_quo <= {r_quo[DivW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DenW-1:0] : w_trial[DenW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/hsvbl_dp.sv =====
// Datapath run by the microcode: HSV terms, brightness ramp, multiplier,
// output register. Depends on hsvbl_pkg and hsvbl_div.
`timescale 1ns / 1ps
`default_nettype none

module hsvbl_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsvbl_pkg::t_ctl   i_ctl,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_rate,
    input  logic              i_in_valid,
    input  logic              i_advance,
    input  logic              i_out_ready,
    output hsvbl_pkg::t_sts   o_sts,
    output logic              o_out_valid,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_level,
    output logic              o_falling
);
    import hsvbl_pkg::*;

    // control state
    logic [7:0] r_lvl;
    logic       r_dim;
    logic       r_out_valid;
    // working registers
    logic            r_adv;
    logic [7:0]      r_s;
    logic [8:0]      r_h;
    logic [2:0]      r_sec;
    logic [5:0]      r_fr;
    logic [DivW-1:0] r_prod;
    logic [DenW-1:0] r_kq;
    logic [DenW-1:0] r_kt;
    logic [7:0]      r_p;
    logic [7:0]      r_q;
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      r_level;
    logic            r_falling;

    logic [7:0]      w_mx;
    logic [7:0]      w_mn;
    logic [7:0]      w_d;
    logic            w_gray;
    logic            w_r_top;
    logic [15:0]     w_num_s;
    logic [16:0]     w_num_h;
    logic [7:0]      w_absgb;
    logic            w_div_start;
    logic [DivW-1:0] w_div_num;
    logic [DenW-1:0] w_div_den;
    logic [CntW-1:0] w_div_cnt;
    logic            w_div_busy;
    logic [DivW-1:0] w_quo;
    logic [7:0]      w_mul_a;
    logic [DenW-1:0] w_mul_b;
    logic [DivW-1:0] w_mul_p;
    logic [DivW+RecW-1:0] w_recip;
    logic [8:0]      w_h_new;
    logic [8:0]      w_sum;
    logic [7:0]      w_up;
    logic [7:0]      w_dn;
    logic [7:0]      n_lvl;
    logic            n_dim;
    logic [2:0]      w_sec;
    logic [8:0]      w_frw;
    logic [16:0]     w_pfix;
    logic [7:0]      w_t;
    logic [7:0]      w_or;
    logic [7:0]      w_og;
    logic [7:0]      w_ob;
    logic            w_out_busy;

    // base color terms
    always_comb begin
        w_mx = i_red;
        w_mn = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx)  w_mx = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn)  w_mn = i_blue;
        w_d     = w_mx - w_mn;
        w_gray  = (w_d == 8'd0);
        w_r_top = (w_mx == i_red);
        w_num_s = {w_d, 8'd0} - {8'd0, w_d};
        w_absgb = (i_green >= i_blue) ? (i_green - i_blue) : (i_blue - i_green);
        if (w_r_top) begin
            w_num_h = 17'(w_absgb) * 17'd60;
        end else if (w_mx == i_green) begin
            w_num_h = 17'(i_blue) * 17'd60 + 17'(w_d) * 17'd120 - 17'(i_red) * 17'd60;
        end else begin
            w_num_h = 17'(i_red) * 17'd60 + 17'(w_d) * 17'd240 - 17'(i_green) * 17'd60;
        end
    end

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = {6'd0, w_mx};
        w_div_cnt   = SCnt;
        case (i_ctl.op)
            OP_S_START: begin
                w_div_start = 1'b1;
                w_div_num   = {w_num_s, 6'd0};
                w_div_den   = {6'd0, w_mx};
                w_div_cnt   = SCnt;
            end
            OP_H_START: begin
                w_div_start = 1'b1;
                w_div_num   = {w_num_h, 5'd0};
                w_div_den   = {6'd0, w_d};
                w_div_cnt   = HCnt;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    hsvbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_cnt   (w_div_cnt),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // shared multiplier operands
    always_comb begin
        case (i_ctl.op)
            OP_MUL_SF: begin
                w_mul_a = r_s;
                w_mul_b = {8'd0, r_fr};
            end
            OP_MUL_SG: begin
                w_mul_a = r_s;
                w_mul_b = {8'd0, SecDeg - r_fr};
            end
            OP_MUL_P: begin
                w_mul_a = r_lvl;
                w_mul_b = {6'd0, Full - r_s};
            end
            OP_MUL_Q: begin
                w_mul_a = r_lvl;
                w_mul_b = r_kq;
            end
            default: begin
                w_mul_a = r_lvl;
                w_mul_b = r_kt;
            end
        endcase
        w_mul_p = DivW'(w_mul_a) * DivW'(w_mul_b);
    end

    // x / 15300 by reciprocal, exact for x <= 255 * 15300
    assign w_recip = (DivW+RecW)'(r_prod) * (DivW+RecW)'(RecipQ);

    // hue fix-up: red-max hue below zero wraps
    always_comb begin
        if (w_r_top && (i_green < i_blue)) begin
            w_h_new = (w_quo[8:0] != 9'd0) ? (Deg360 - w_quo[8:0]) : 9'd0;
        end else begin
            w_h_new = w_quo[8:0];
        end
    end

    // ramp
    always_comb begin
        w_sum = {1'b0, r_lvl} + {1'b0, i_rate};
        w_up  = w_sum[8] ? Full : w_sum[7:0];
        w_dn  = (r_lvl > i_rate) ? (r_lvl - i_rate) : 8'd0;
        n_lvl = r_lvl;
        n_dim = r_dim;
        if (r_adv) begin
            if (!r_dim) begin
                n_lvl = w_up;
                if (w_up >= w_mx) begin
                    n_lvl = w_mx;
                    n_dim = 1'b1;
                end
            end else begin
                n_lvl = w_dn;
                if (w_dn <= LowThr) begin
                    n_lvl = 8'd0;
                    n_dim = 1'b0;
                end
            end
        end
    end

    // sector and offset of hue
    always_comb begin
        if (r_h >= 9'd300) begin
            w_sec = 3'd5;
            w_frw = r_h - 9'd300;
        end else if (r_h >= 9'd240) begin
            w_sec = 3'd4;
            w_frw = r_h - 9'd240;
        end else if (r_h >= 9'd180) begin
            w_sec = 3'd3;
            w_frw = r_h - 9'd180;
        end else if (r_h >= 9'd120) begin
            w_sec = 3'd2;
            w_frw = r_h - 9'd120;
        end else if (r_h >= 9'd60) begin
            w_sec = 3'd1;
            w_frw = r_h - 9'd60;
        end else begin
            w_sec = 3'd0;
            w_frw = r_h;
        end
    end

    // x / 255 for x < 65535
    assign w_pfix = 17'(r_prod[15:0]) + 17'd1 + 17'(r_prod[15:8]);

    assign w_t = w_recip[RecSh+7:RecSh];

    always_comb begin
        case (r_sec)
            3'd0: begin w_or = r_lvl; w_og = w_t;   w_ob = r_p;   end
            3'd1: begin w_or = r_q;   w_og = r_lvl; w_ob = r_p;   end
            3'd2: begin w_or = r_p;   w_og = r_lvl; w_ob = w_t;   end
            3'd3: begin w_or = r_p;   w_og = r_q;   w_ob = r_lvl; end
            3'd4: begin w_or = w_t;   w_og = r_p;   w_ob = r_lvl; end
            default: begin w_or = r_lvl; w_og = r_p; w_ob = r_q; end
        endcase
    end

    assign w_out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl       <= 8'd0;
            r_dim       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.op == OP_RAMP) begin
                r_lvl <= n_lvl;
                r_dim <= n_dim;
            end
            if ((i_ctl.op == OP_EMIT) && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_IDLE: begin
                if (i_in_valid) r_adv <= i_advance;
            end
            OP_S_STORE: r_s <= w_quo[7:0];
            OP_H_STORE: r_h <= w_h_new;
            OP_GRAY: begin
                r_s <= 8'd0;
                r_h <= 9'd0;
            end
            OP_RAMP: begin
                r_sec <= w_sec;
                r_fr  <= w_frw[5:0];
            end
            OP_MUL_SF: r_prod <= w_mul_p;
            OP_MUL_SG: begin
                r_kq   <= ScaleQ - r_prod[DenW-1:0];
                r_prod <= w_mul_p;
            end
            OP_MUL_P: begin
                r_kt   <= ScaleQ - r_prod[DenW-1:0];
                r_prod <= w_mul_p;
            end
            OP_MUL_Q: begin
                r_p    <= w_pfix[15:8];
                r_prod <= w_mul_p;
            end
            OP_MUL_T: begin
                r_q    <= w_recip[RecSh+7:RecSh];
                r_prod <= w_mul_p;
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_red     <= w_or;
                    r_green   <= w_og;
                    r_blue    <= w_ob;
                    r_level   <= r_lvl;
                    r_falling <= r_dim;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.in_valid = i_in_valid;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.out_busy = w_out_busy;
    assign o_sts.gray     = w_gray;

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_level     = r_level;
    assign o_falling   = r_falling;

endmodule

`default_nettype wire

// ===== rtl/hsv_breathing_light_top.sv =====
// Top level of the HSV breathing light: register file, channel hookup,
// sequencer and datapath. Depends on hsvbl_pkg, hsvbl_if, hsvbl_seq, hsvbl_dp.
`timescale 1ns / 1ps
`default_nettype none

// Each tick transfer on i_in yields one color transfer on o_out. The single
// shared divider produces one quotient bit per cycle for saturation and hue;
// a gray base color, with equal components, skips both divisions. The next
// tick is taken in the cycle after the result is registered, while that
// result still waits on o_out. Register writes on i_cfg are always accepted
// and take effect at once; write them only between ticks.

module hsv_breathing_light_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvbl_in_if.sink    i_in,
    hsvbl_out_if.source o_out,
    hsvbl_cfg_if.sink   i_cfg
);
    import hsvbl_pkg::*;

    logic [7:0] r_base_red;
    logic [7:0] r_base_green;
    logic [7:0] r_base_blue;
    logic [7:0] r_step_rate;
    t_ctl       w_ctl;
    t_sts       w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_red   <= 8'd255;
            r_base_green <= 8'd0;
            r_base_blue  <= 8'd0;
            r_step_rate  <= 8'd5;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_RED:   r_base_red   <= i_cfg.data;
                REG_GREEN: r_base_green <= i_cfg.data;
                REG_BLUE:  r_base_blue  <= i_cfg.data;
                REG_RATE:  r_step_rate  <= i_cfg.data;
                default:   r_step_rate  <= r_step_rate;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_ctl.in_ready;

    hsvbl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    hsvbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_red       (r_base_red),
        .i_green     (r_base_green),
        .i_blue      (r_base_blue),
        .i_rate      (r_step_rate),
        .i_in_valid  (i_in.valid),
        .i_advance   (i_in.advance),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out.valid),
        .o_red       (o_out.red),
        .o_green     (o_out.green),
        .o_blue      (o_out.blue),
        .o_level     (o_out.level),
        .o_falling   (o_out.falling)
    );

endmodule

`default_nettype wire

// ===== rtl/hsvbl_chk.sv =====
// Port-level checker for hsv_breathing_light_top and its bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module hsvbl_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic [7:0] i_level,
    input logic       i_falling
);

    // one tick in flight
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("tick taken while another is in flight");

    // a new result appears only as the sequencer returns to idle
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result raised while a tick is still in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_red) && $stable(i_green) && $stable(i_blue)
             && $stable(i_level) && $stable(i_falling)))
        else $error("result changed while stalled");

endmodule

bind hsv_breathing_light_top hsvbl_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue),
    .i_level     (o_out.level),
    .i_falling   (o_out.falling)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for hsv_breathing_light_top: directed and random breathing ticks, with
// random stalls on both sides. Each color is checked against an in-bench HSV ramp model.
// Depends on hsvbl_pkg, hsvbl_if and the RTL of the top level.
`timescale 1ns / 1ps

module tb_top;
    import hsvbl_pkg::*;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int unsigned DrainCycles = 120;
    localparam int unsigned RandomTicks = 1200;
    localparam int unsigned QuietTail   = 150;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
        logic       falling;
    } t_color;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic color_ready = 1'b0;

    hsvbl_in_if  tick_if ();
    hsvbl_out_if color_if ();
    hsvbl_cfg_if cfg_if ();

    assign color_if.ready = color_ready;

    hsv_breathing_light_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (tick_if),
        .o_out  (color_if),
        .i_cfg  (cfg_if)
    );

    // Model copy of the registers and the ramp state
    int unsigned base_r = 255;
    int unsigned base_g = 0;
    int unsigned base_b = 0;
    int unsigned ramp_rate = 5;
    int unsigned bright = 0;
    logic        dimming = 1'b0;

    t_color      expected_colors[$];
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    logic        idle_on = 1'b1;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Color sink starts random stall bursts while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            color_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            color_ready <= 1'b0;
        end else begin
            color_ready <= 1'b1;
        end
    end

    // Applies one tick to the ramp state and returns the color it yields
    function automatic t_color next_color(input logic adv);
        int unsigned mx, mn, d, hue, sat, nb, sector, fr, p, q, t;
        t_color c;
        mx = base_r;
        mn = base_r;
        if (base_g > mx) mx = base_g;
        if (base_b > mx) mx = base_b;
        if (base_g < mn) mn = base_g;
        if (base_b < mn) mn = base_b;
        d   = mx - mn;
        sat = (mx == 0) ? 0 : (Full * d) / mx;
        if (d == 0) begin
            hue = 0;
        end else if (mx == base_r) begin
            if (base_g >= base_b) begin
                hue = (SecDeg * (base_g - base_b)) / d;
            end else begin
                hue = (SecDeg * (base_b - base_g)) / d;
                if (hue != 0) hue = Deg360 - hue;
            end
        end else if (mx == base_g) begin
            hue = (SecDeg * base_b + 120 * d - SecDeg * base_r) / d;
        end else begin
            hue = (SecDeg * base_r + 240 * d - SecDeg * base_g) / d;
        end

        if (adv) begin
            if (!dimming) begin
                nb = bright + ramp_rate;
                if (nb > Full) nb = 32'(Full);
                if (nb >= mx) begin
                    nb      = mx;
                    dimming = 1'b1;
                end
            end else begin
                nb = (bright > ramp_rate) ? bright - ramp_rate : 0;
                if (nb <= LowThr) begin
                    nb      = 0;
                    dimming = 1'b0;
                end
            end
            bright = nb;
        end

        sector = (hue / SecDeg) % 6;
        fr     = hue % SecDeg;
        p = (bright * (Full - sat)) / Full;
        q = (bright * (ScaleQ - sat * fr)) / ScaleQ;
        t = (bright * (ScaleQ - sat * (SecDeg - fr))) / ScaleQ;
        case (sector)
            0: begin c.red = 8'(bright); c.green = 8'(t); c.blue = 8'(p); end
            1: begin c.red = 8'(q); c.green = 8'(bright); c.blue = 8'(p); end
            2: begin c.red = 8'(p); c.green = 8'(bright); c.blue = 8'(t); end
            3: begin c.red = 8'(p); c.green = 8'(q); c.blue = 8'(bright); end
            4: begin c.red = 8'(t); c.green = 8'(p); c.blue = 8'(bright); end
            default: begin c.red = 8'(bright); c.green = 8'(p); c.blue = 8'(q); end
        endcase
        c.level   = 8'(bright);
        c.falling = dimming;
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Outputs are stable at the falling edge; a transfer seen here lands at the next rise
    always @(negedge i_clk) begin : check_color
        t_color got;
        t_color want;
        if (i_rst_n && color_if.valid && color_if.ready) begin
            got = {color_if.red, color_if.green, color_if.blue, color_if.level,
                   color_if.falling};
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected color: expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_colors.pop_front();
                check_field("red", 32'(want.red), 32'(got.red));
                check_field("green", 32'(want.green), 32'(got.green));
                check_field("blue", 32'(want.blue), 32'(got.blue));
                check_field("level", 32'(want.level), 32'(got.level));
                check_field("falling", 32'(want.falling), 32'(got.falling));
            end
        end
    end

    task automatic send_tick(input logic adv);
        logic taken;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.advance <= adv;
        do begin
            @(negedge i_clk);
            taken = tick_if.ready;
            @(posedge i_clk);
        end while (!taken);
        expected_colors.push_back(next_color(adv));
    endtask

    task automatic wait_drain();
        while (expected_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [7:0] val);
        logic taken;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(negedge i_clk);
            taken = cfg_if.ready;
            @(posedge i_clk);
        end while (!taken);
        case (idx)
            REG_RED:   base_r    = 32'(val);
            REG_GREEN: base_g    = 32'(val);
            REG_BLUE:  base_b    = 32'(val);
            REG_RATE:  ramp_rate = 32'(val);
            default: ;
        endcase
    endtask

    // Registers change only with the block idle
    task automatic set_config(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] step);
        tick_if.valid <= 1'b0;
        wait_drain();
        write_reg(REG_RED, r);
        write_reg(REG_GREEN, g);
        write_reg(REG_BLUE, b);
        write_reg(REG_RATE, step);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // One tick per hue branch, plus gray and black
    task automatic test_hue_sectors();
        logic [23:0] bases [7] = '{24'hFF8000, 24'hC80A5A, 24'h1EDC64, 24'h283CFA,
                                   24'h808080, 24'h000000, 24'hFF00FF};
        foreach (bases[i]) begin
            set_config(bases[i][23:16], bases[i][15:8], bases[i][7:0], 8'd255);
            send_tick(1'b1);
        end
    endtask

    // Brightening clips at full scale, dimming clips at zero
    task automatic test_ramp_limits();
        set_config(8'd255, 8'd255, 8'd255, 8'd200);
        repeat (4) send_tick(1'b1);
    endtask

    task automatic test_base_change();
        set_config(8'd255, 8'd255, 8'd255, 8'd100);
        repeat (3) send_tick(1'b1);
        set_config(8'd40, 8'd0, 8'd200, 8'd30);
        repeat (2) send_tick(1'b1);
    endtask

    task automatic test_zero_rate();
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        set_config(8'd255, 8'd0, 8'd0, 8'd0);
        send_tick(1'b1);
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_rate();
        case ($urandom_range(0, 15))
            0: return 8'd0;
            1, 2: return 8'd255;
            3, 4, 5: return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic test_random_ramps();
        int unsigned sent;
        int unsigned phase_len;
        logic [7:0] r, g, b;
        sent = 0;
        while (sent < RandomTicks) begin
            phase_len = $urandom_range(40, 120);
            r = rand_level();
            g = rand_level();
            b = rand_level();
            if ($urandom_range(0, 7) == 0) begin
                g = r;
                b = r;
            end
            set_config(r, g, b, rand_rate());
            idle_on = (sent + phase_len + QuietTail < RandomTicks) &&
                      ($urandom_range(0, 3) != 0);
            repeat (phase_len) begin
                if ($urandom_range(0, 80) == 0) begin
                    tick_if.valid <= 1'b0;
                    wait_drain();
                end
                send_tick($urandom_range(0, 7) != 0);
            end
            sent += phase_len;
        end
    endtask

    initial begin
        tick_if.valid   <= 1'b0;
        tick_if.advance <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_RED;
        cfg_if.data     <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_hue_sectors();
        test_ramp_limits();
        test_base_change();
        test_zero_rate();
        test_random_ramps();

        tick_if.valid <= 1'b0;
        wait_drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
